// ===== sv/imu_spi_transaction_engine_assert.svh =====
// assertion macros for the spi transaction engine
`ifndef IMU_SPI_TRANSACTION_ENGINE_ASSERT_SVH
`define IMU_SPI_TRANSACTION_ENGINE_ASSERT_SVH
// holds: a then b in the same cycle
`define ISTE_ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// holds that a is followed by b in the next cycle
`define ISTE_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== sv/iste_pkg.sv =====
package iste_pkg;
  localparam int FrameBits = 16;
  localparam logic [3:0] MaxBurstWords = 4'd12;
  localparam logic [1:0] CMD_READ = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_BURST = 2'd2;
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LEAD = 3'd1;
  localparam logic [2:0] PH_GAP = 3'd2;
  localparam logic [2:0] PH_TRAIL = 3'd3;
  localparam logic [2:0] PH_LOW = 3'd4;
  localparam logic [2:0] PH_HIGH = 3'd5;
  localparam logic [1:0] REG_HALF = 2'd0;
  localparam logic [1:0] REG_BURST_HALF = 2'd1;
  localparam logic [1:0] REG_GAP = 2'd2;
  localparam logic [1:0] REG_SETUP = 2'd3;

  typedef struct packed {
    logic        start;
    logic [1:0]  command;
    logic [6:0]  reg_address;
    logic [15:0] write_value;
    logic [3:0]  count;
    logic        miso;
  } tick_t;

  typedef struct packed {
    logic        sclk;
    logic        mosi;
    logic        cs;
    logic        busy;
    logic        word_valid;
    logic [15:0] word_data;
    logic [3:0]  word_index;
    logic        last_word;
    logic        error;
  } res_t;

  function automatic logic [15:0] post_burst(input logic [15:0] raw, input logic [3:0] idx);
    logic [15:0] r;
    r = 16'd0;
    if (idx == 4'd0) r = raw & 16'h1fff;
    else if (idx == 4'd10) r = raw[11] ? (raw | 16'hF000) : (raw & 16'h07FF);
    else r = raw[13] ? (raw | 16'hE000) : (raw & 16'h1fff);
    return r;
  endfunction
endpackage

// ===== sv/iste_queue.sv =====
module iste_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  iste_pkg::tick_t wdata,
  output logic            full,
  output logic            nempty,
  input  logic            rd,
  output iste_pkg::tick_t rdata
);
  import iste_pkg::*;
  tick_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  assign full = cnt == 2'd2;
  assign nempty = cnt != 2'd0;
  assign rdata = mem[rp];
  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// ===== sv/iste_front.sv =====
module iste_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            start_req,
  input  logic [1:0]      command,
  input  logic [6:0]      reg_address,
  input  logic [15:0]     write_value,
  input  logic [3:0]      burst_count,
  input  logic            miso_in,
  output logic            q_wr,
  output iste_pkg::tick_t q_data,
  input  logic            q_full
);
  import iste_pkg::*;
  // classify: clamp burst count
  logic [3:0] cnt;
  assign cnt = (burst_count == 4'd0 || burst_count > MaxBurstWords) ? MaxBurstWords
                                                                    : burst_count;
  assign in_stall = q_full;
  assign q_wr = in_valid && !q_full;
  assign q_data = '{start: start_req, command: command, reg_address: reg_address,
                    write_value: write_value, count: cnt, miso: miso_in};
endmodule

// ===== sv/iste_back.sv =====
module iste_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  iste_pkg::tick_t t,
  input  logic [15:0]     reg_half,
  input  logic [15:0]     burst_half,
  input  logic [15:0]     gap,
  input  logic [15:0]     setup,
  output iste_pkg::res_t  r
);
  import iste_pkg::*;
  logic [2:0] phase, phase_next;
  logic [15:0] tick, tick_next, tx, tx_next, rx, rx_next;
  logic [4:0] bitc, bitc_next;
  logic [3:0] frame, frame_next;
  logic [1:0] cmd, cmd_next;
  logic [6:0] addr, addr_next;
  logic [15:0] val, val_next;
  logic [3:0] cnt, cnt_next;
  logic sclk, sclk_next, mosi, mosi_next, cs, cs_next;
  res_t res_next;
  logic [15:0] h, hh, hb, hr;
  logic bad;
  logic [4:0] b1;
  logic [3:0] idx;

  always_comb begin
    h = (cmd == CMD_BURST) ? burst_half : reg_half;
    hh = (h == 16'd0) ? 16'd0 : h - 16'd1;
    hb = (burst_half == 16'd0) ? 16'd0 : burst_half - 16'd1;
    hr = (reg_half == 16'd0) ? 16'd0 : reg_half - 16'd1;
    bad = t.command == CMD_WRITE && (t.reg_address > 7'h4A || t.reg_address[0]);
    b1 = bitc + 5'd1;
    idx = frame - 4'd1;
    phase_next = phase; tick_next = tick; tx_next = tx; rx_next = rx;
    bitc_next = bitc; frame_next = frame; cmd_next = cmd; addr_next = addr;
    val_next = val; cnt_next = cnt; sclk_next = sclk; mosi_next = mosi; cs_next = cs;
    res_next = '0;
    priority case (1'b1)
      phase == PH_IDLE: begin
        if (t.start && t.command != 2'd3) begin
          if (bad) res_next.error = 1'b1;
          else begin
            cmd_next = t.command; addr_next = t.reg_address;
            val_next = t.write_value; cnt_next = t.count;
            frame_next = 4'd0; rx_next = 16'd0; cs_next = 1'b0;
            phase_next = PH_LEAD;
            tick_next = (t.command == CMD_BURST) ? setup : gap;
            if (t.command == CMD_READ) tx_next = {1'b0, t.reg_address, 8'h00};
            else if (t.command == CMD_WRITE)
              tx_next = {1'b1, t.reg_address + 7'd1, t.write_value[15:8]};
            else tx_next = 16'h3E00;
          end
        end
      end
      tick != 16'd0: tick_next = tick - 16'd1;
      phase == PH_LOW: begin
        sclk_next = 1'b1; rx_next = {rx[14:0], t.miso};
        phase_next = PH_HIGH; tick_next = hh;
      end
      phase == PH_HIGH: begin
        bitc_next = b1;
        if (b1 < 5'(FrameBits)) begin
          tx_next = {tx[14:0], 1'b0};
          phase_next = PH_LOW; sclk_next = 1'b0; mosi_next = tx[14]; tick_next = hh;
        end else begin
          frame_next = frame + 4'd1;
          if (frame == 4'd0) begin
            tx_next = (cmd == CMD_WRITE) ? {1'b1, addr, val[7:0]} : 16'd0;
            phase_next = PH_GAP; tick_next = gap;
          end else if (cmd == CMD_READ) begin
            res_next.word_valid = 1'b1; res_next.word_data = rx;
            res_next.last_word = 1'b1; phase_next = PH_TRAIL; tick_next = gap;
          end else if (cmd == CMD_WRITE) begin
            phase_next = PH_TRAIL; tick_next = gap;
          end else begin
            res_next.word_valid = 1'b1; res_next.word_data = post_burst(rx, idx);
            res_next.word_index = idx; res_next.last_word = frame >= cnt;
            if (frame < cnt) begin
              tx_next = 16'd0; phase_next = PH_LOW; bitc_next = 5'd0;
              sclk_next = 1'b0; mosi_next = 1'b0; tick_next = hb;
            end else begin
              phase_next = PH_TRAIL; tick_next = setup;
            end
          end
        end
      end
      phase == PH_TRAIL: begin
        cs_next = 1'b1; mosi_next = 1'b0; phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_LOW; bitc_next = 5'd0; sclk_next = 1'b0;
        mosi_next = tx[15]; tick_next = (cmd == CMD_BURST) ? hb : hr;
      end
    endcase
    res_next.sclk = sclk_next; res_next.mosi = mosi_next; res_next.cs = cs_next;
    res_next.busy = phase_next != PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; tick <= '0; bitc <= '0; frame <= '0; tx <= '0; rx <= '0;
      cmd <= '0; addr <= '0; val <= '0; cnt <= '0;
      sclk <= 1'b1; cs <= 1'b1; mosi <= 1'b0;
      r <= '0;
    end else if (go) begin
      phase <= phase_next; tick <= tick_next; bitc <= bitc_next; frame <= frame_next;
      tx <= tx_next; rx <= rx_next; cmd <= cmd_next; addr <= addr_next;
      val <= val_next; cnt <= cnt_next;
      sclk <= sclk_next; cs <= cs_next; mosi <= mosi_next;
      r <= res_next;
    end
  end
endmodule

// ===== sv/imu_spi_transaction_engine.sv =====
// channel | direction | handshake
// in      | input     | in_valid / in_stall
// out     | output    | out_valid / out_stall
// one tick per cycle while in_stall is low; each accepted tick gives one result at the output
// an accepted tick passes through the queue, then the back end steps into an output register
// the back end steps only when the output register is free or being taken
// rst is synchronous; the output register clears, so pins read sclk low, cs low, mosi low
`include "imu_spi_transaction_engine_assert.svh"
module imu_spi_transaction_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        start_req,
  input  logic [1:0]  command,
  input  logic [6:0]  reg_address,
  input  logic [15:0] write_value,
  input  logic [3:0]  burst_count,
  input  logic        miso_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        sclk_out,
  output logic        mosi_out,
  output logic        cs_out,
  output logic        busy_res,
  output logic        word_valid,
  output logic [15:0] word_data,
  output logic [3:0]  word_index,
  output logic        last_word,
  output logic        error
);
  import iste_pkg::*;
  logic [15:0] reg_half, burst_half, gap, setup;
  logic q_wr, q_full, q_ne, go;
  tick_t q_in, q_out;
  res_t r;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_half <= 16'd100; burst_half <= 16'd12; gap <= 16'd250; setup <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF: reg_half <= cfg_data;
        REG_BURST_HALF: burst_half <= cfg_data;
        REG_GAP: gap <= cfg_data;
        REG_SETUP: setup <= cfg_data;
        default: ;
      endcase
    end
  end

  iste_front u_front (.in_valid, .in_stall, .start_req, .command, .reg_address,
    .write_value, .burst_count, .miso_in, .q_wr, .q_data(q_in), .q_full);

  assign go = q_ne && (!out_valid || !out_stall);
  iste_queue u_queue (.clk, .rst, .wr(q_wr), .wdata(q_in), .full(q_full), .nempty(q_ne),
    .rd(go), .rdata(q_out));

  iste_back u_back (.clk, .rst, .go, .t(q_out), .reg_half, .burst_half, .gap, .setup, .r);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (go) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  assign sclk_out = r.sclk;
  assign mosi_out = r.mosi;
  assign cs_out = r.cs;
  assign busy_res = r.busy;
  assign word_valid = r.word_valid;
  assign word_data = r.word_data;
  assign word_index = r.word_index;
  assign last_word = r.last_word;
  assign error = r.error;

  `ISTE_ASSERT_IMPL(a_err_idle, out_valid && error, !busy_res && cs_out)
  `ISTE_ASSERT_IMPL(a_word_busy, out_valid && word_valid, busy_res && !cs_out)
  `ISTE_ASSERT_NEXT(a_go_out, go, out_valid)
endmodule
